/* hdl/bpc_pkg.sv */
// Package: shared types, constants and op codes for pressure compensation.
package bpc_pkg;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	localparam int NUM_REGS = 6;
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	typedef struct packed {
		logic        operation;
		logic [23:0] raw_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               error;
	} out_item_t;

	// divider request/response between sequencer and divider
	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage

/* hdl/bpc_div.sv */
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
module bpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bpc_pkg::div_req_t  req,
	output bpc_pkg::div_rsp_t  rsp
);

	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	// shift in next dividend bit and trial-subtract
	always_comb begin
		trial = {rem_q, quo_q[31]} - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

/* hdl/barometric_pressure_compensation.sv */
// Top level: sequencer with one shared multiplier and a serial divider.
//
// Barometric pressure compensation. Five calibration registers and an
// oversampling register are written through the cfg_we/cfg_index/cfg_data
// port; the user must write them only while the block is idle, since the
// block itself does not enforce it. Input transactions (in_valid/in_ready)
// carry an operation (0 temperature, 1 pressure) and the raw reading.
// Each input transaction gives exactly one output transaction
// (out_valid/out_ready) with the value and a divide-by-zero error flag.
// A temperature item stores its B5 term for later pressure items.
// Work runs through one 32x32 signed multiplier, one product per cycle,
// and one bit-serial divider. An item whose divisor is zero skips the
// division and goes straight to the output with the error flag set.
// One item is processed at a time; in_ready is low while an item is at
// work. The result waits in an output register while out_ready is low;
// in_ready rises again the cycle after the result is taken.
// Reset clears the registers, the stored B5 and all control state.
module barometric_pressure_compensation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpc_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bpc_pkg::out_item_t  out_item
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T1   = 5'd1;  // (ut-ac6)*ac5
	localparam logic [4:0] S_T2   = 5'd2;  // divide mc*2048 / den
	localparam logic [4:0] S_T3   = 5'd3;  // wait divider
	localparam logic [4:0] S_P1   = 5'd4;  // b6*b6
	localparam logic [4:0] S_P2   = 5'd5;  // b2*sq
	localparam logic [4:0] S_P3   = 5'd6;  // ac2*b6
	localparam logic [4:0] S_P4   = 5'd7;  // (ac1*4+x3)<<oss ; ac3*b6
	localparam logic [4:0] S_P5   = 5'd8;  // b1*sq
	localparam logic [4:0] S_P6   = 5'd9;  // ac4*(x3+32768)
	localparam logic [4:0] S_P7   = 5'd10; // (up-b3)*(50000>>oss)
	localparam logic [4:0] S_P8   = 5'd11; // start divide
	localparam logic [4:0] S_P9   = 5'd12; // wait divide
	localparam logic [4:0] S_P10  = 5'd13; // q*q
	localparam logic [4:0] S_P11  = 5'd14; // x1*3038
	localparam logic [4:0] S_P12  = 5'd15; // -7357*p
	localparam logic [4:0] S_P13  = 5'd16; // final sum
	localparam logic [4:0] S_OUT  = 5'd17;

	logic [31:0] cfg_q [5];
	logic [1:0]  oss_q;
	logic signed [31:0] b5_q;
	logic [4:0]  state_q;
	logic [23:0] raw_q;
	logic signed [31:0] a_q, b_q, c_q, d_q, e_q;
	logic        sign_q;
	logic        ovf_q;
	logic signed [31:0] res_q;
	logic        err_q;

	// shared multiplier operands
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [31:0] p32;

	bpc_pkg::div_req_t dreq;
	bpc_pkg::div_rsp_t drsp;

	// calibration fields
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0] ac4, ac5, ac6;
	assign ac1 = 32'(signed'(cfg_q[0][31:16]));
	assign ac2 = 32'(signed'(cfg_q[0][15:0]));
	assign ac3 = 32'(signed'(cfg_q[1][31:16]));
	assign ac4 = {16'd0, cfg_q[1][15:0]};
	assign ac5 = {16'd0, cfg_q[2][31:16]};
	assign ac6 = {16'd0, cfg_q[2][15:0]};
	assign b1  = 32'(signed'(cfg_q[3][31:16]));
	assign b2  = 32'(signed'(cfg_q[3][15:0]));
	assign mc  = 32'(signed'(cfg_q[4][31:16]));
	assign md  = 32'(signed'(cfg_q[4][15:0]));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) cfg_q[i] <= '0;
			oss_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == bpc_pkg::REG_OSS) oss_q <= cfg_data[1:0];
			else if (cfg_index < bpc_pkg::REG_OSS) cfg_q[cfg_index] <= cfg_data;
		end
	end

	// multiplier operand selection
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_T1: begin
				ma = $signed({16'd0, raw_q[15:0]}) - $signed(ac6);
				mb = $signed(ac5);
			end
			S_P1:  begin ma = a_q; mb = a_q; end
			S_P2:  begin ma = b2; mb = b_q; end
			S_P3:  begin ma = ac2; mb = a_q; end
			S_P4:  begin ma = ac3; mb = a_q; end
			S_P5:  begin ma = b1; mb = b_q; end
			S_P6:  begin ma = $signed(ac4); mb = e_q; end
			S_P7: begin
				ma = $signed(32'(raw_q >> (4'd8 - {2'd0, oss_q}))) - c_q;
				mb = $signed(32'(32'd50000 >> oss_q));
			end
			S_P10: begin ma = a_q >>> 8; mb = a_q >>> 8; end
			S_P11: begin ma = b_q; mb = 32'sd3038; end
			S_P12: begin ma = a_q; mb = -32'sd7357; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod = ma * mb;
	assign p32  = prod[31:0];

	// divider takes magnitudes; the temperature quotient sign is applied afterwards
	assign dreq.start = (state_q == S_T2) || (state_q == S_P8);
	assign dreq.num = (state_q == S_T2) ? (d_q[31] ? -d_q : d_q) : (ovf_q ? d_q : d_q << 1);
	assign dreq.den = (state_q == S_T2) ? (b_q[31] ? -b_q : b_q) : e_q;

	bpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic signed [31:0] x1t, den_t, tmp, b3t, x3t, pu, b5n;
	always_comb begin
		x1t   = p32 >>> 15;
		den_t = x1t + md;
		tmp   = 32'((ac1 <<< 2) + d_q) <<< oss_q;
		b3t   = (tmp + 32'sd2) >>> 2;
		x3t   = ((d_q + (p32 >>> 16)) + 32'sd2) >>> 2;
		pu    = ovf_q ? (drsp.quo << 1) : drsp.quo;
		b5n   = a_q + $signed(sign_q ? -drsp.quo : drsp.quo);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			b5_q    <= '0;
			res_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					raw_q <= in_item.raw_value;
					a_q   <= b5_q - 32'sd4000;
					state_q <= (in_item.operation == bpc_pkg::OP_TEMP) ? S_T1 : S_P1;
				end
				S_T1: begin
					a_q <= x1t;
					b_q <= den_t;
					d_q <= mc <<< 11;
					sign_q <= mc[31] ^ den_t[31];
					if (den_t == 0) begin
						res_q <= '0; err_q <= 1'b1; state_q <= S_OUT;
					end else state_q <= S_T2;
				end
				S_T2: state_q <= S_T3;
				S_T3: if (drsp.done) begin
					b5_q  <= b5n;
					res_q <= (b5n + 32'sd8) >>> 4;
					err_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_P1: begin b_q <= p32 >>> 12; state_q <= S_P2; end
				S_P2: begin d_q <= p32 >>> 11; state_q <= S_P3; end
				S_P3: begin d_q <= d_q + (p32 >>> 11); state_q <= S_P4; end
				S_P4: begin c_q <= b3t; d_q <= p32 >>> 13; state_q <= S_P5; end
				S_P5: begin e_q <= x3t + 32'sd32768; state_q <= S_P6; end
				S_P6: begin e_q <= $signed(p32 >> 15); state_q <= S_P7; end
				S_P7: begin
					d_q <= p32;
					ovf_q <= p32[31];
					if (e_q == 0) begin
						res_q <= '0; err_q <= 1'b1; state_q <= S_OUT;
					end else state_q <= S_P8;
				end
				S_P8: state_q <= S_P9;
				S_P9: if (drsp.done) begin a_q <= pu; state_q <= S_P10; end
				S_P10: begin b_q <= p32; state_q <= S_P11; end
				S_P11: begin c_q <= p32 >>> 16; state_q <= S_P12; end
				S_P12: begin c_q <= c_q + (p32 >>> 16); state_q <= S_P13; end
				S_P13: begin
					res_q <= a_q + ((c_q + 32'sd3791) >>> 4);
					err_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = (state_q == S_OUT);
	assign out_item.value = res_q;
	assign out_item.error = err_q;

	// error results always carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.error |-> out_item.value == 0)
		else $error("error result with nonzero value");

	// a result is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result dropped while stalled");

	// no input taken while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");

endmodule

/* test/barometric_pressure_compensation_tb.sv */
// Testbench for barometric pressure compensation: predictor, driver, monitor.
module barometric_pressure_compensation_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS = 1450;
	localparam longint CYCLE_LIMIT = 2000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	bpc_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	bpc_pkg::out_item_t out_item;

	barometric_pressure_compensation u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// predictor copy of calibration and stored B5
	logic [31:0] cal_regs [0:4];
	logic [1:0]  oss_reg;
	logic signed [31:0] b5_term;

	bpc_pkg::in_item_t  pending_items [$];
	bpc_pkg::out_item_t expected_results [$];
	int  errors = 0;
	int  results_seen = 0;
	int  div_errors_seen = 0;
	longint cycle_count = 0;
	bit  hold_sender = 0;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// floor shift of a 32-bit signed word
	function automatic logic signed [31:0] asr32(input logic signed [31:0] v, input int s);
		return v >>> s;
	endfunction

	// compute one result, updating stored B5
	function automatic bpc_pkg::out_item_t compensate(input bpc_pkg::in_item_t it);
		bpc_pkg::out_item_t r;
		logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
		logic signed [31:0] ac4, ac5, ac6;
		logic signed [31:0] x1, x2, x3, den, b5, b6, sq, t, b3, p, q;
		logic [31:0] up, b4, b7, pu;
		longint num, dq;
		int oss;
		ac1 = {{16{cal_regs[0][31]}}, cal_regs[0][31:16]};
		ac2 = {{16{cal_regs[0][15]}}, cal_regs[0][15:0]};
		ac3 = {{16{cal_regs[1][31]}}, cal_regs[1][31:16]};
		ac4 = {16'd0, cal_regs[1][15:0]};
		ac5 = {16'd0, cal_regs[2][31:16]};
		ac6 = {16'd0, cal_regs[2][15:0]};
		b1 = {{16{cal_regs[3][31]}}, cal_regs[3][31:16]};
		b2 = {{16{cal_regs[3][15]}}, cal_regs[3][15:0]};
		mc = {{16{cal_regs[4][31]}}, cal_regs[4][31:16]};
		md = {{16{cal_regs[4][15]}}, cal_regs[4][15:0]};
		oss = oss_reg;
		r.value = '0;
		r.error = 1'b0;
		if (it.operation == bpc_pkg::OP_TEMP) begin
			x1 = asr32(($signed({16'd0, it.raw_value[15:0]}) - ac6) * ac5, 15);
			den = x1 + md;
			if (den == 0) begin
				r.error = 1'b1;
			end else begin
				// truncating 64-bit division, as in C
				num = longint'(mc) * 2048;
				dq = num / longint'(den);
				x2 = dq[31:0];
				b5 = x1 + x2;
				b5_term = b5;
				r.value = asr32(b5 + 8, 4);
			end
		end else begin
			up = {8'd0, it.raw_value} >> (8 - oss);
			b6 = b5_term - 4000;
			sq = asr32(b6 * b6, 12);
			x1 = asr32(b2 * sq, 11);
			x2 = asr32(ac2 * b6, 11);
			x3 = x1 + x2;
			t = (ac1 * 4 + x3) << oss;
			b3 = asr32(t + 2, 2);
			x1 = asr32(ac3 * b6, 13);
			x2 = asr32(b1 * sq, 16);
			x3 = asr32(x1 + x2 + 2, 2);
			b4 = (ac4 * (x3 + 32768)) >> 15;
			b7 = (up - b3) * (32'd50000 >> oss);
			if (b4 == 0) begin
				r.error = 1'b1;
			end else begin
				pu = (b7 < 32'h80000000) ? (b7 * 2) / b4 : (b7 / b4) * 2;
				p = pu;
				q = asr32(p, 8);
				x1 = q * q;
				x1 = asr32(x1 * 3038, 16);
				x2 = asr32(-7357 * p, 16);
				r.value = p + asr32(x1 + x2 + 3791, 4);
			end
		end
		return r;
	endfunction

	// driver: bursts with random gaps, payload held until accepted
	int gap_left = 0;
	int burst_left = 0;
	always @(posedge clk or negedge arst_n) begin
		bpc_pkg::in_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(compensate(in_item));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0 && !hold_sender) begin
					nxt = pending_items.pop_front();
					in_valid <= 1'b1;
					in_item  <= nxt;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(12, 1);
						gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: receiver stall pattern and result check
	logic [7:0] stall_pat;
	always @(posedge clk or negedge arst_n) begin
		bpc_pkg::out_item_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_pat <= 8'hff;
		end else begin
			if (($urandom_range(63)) == 0) begin
				stall_pat <= 8'($urandom);
			end else begin
				stall_pat <= {stall_pat[6:0], stall_pat[7]};
			end
			out_ready <= stall_pat[0] | ($urandom_range(3) == 0);
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_item.error) begin
					div_errors_seen++;
				end
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value=%0d error=%0b",
						$time, out_item.value, out_item.error);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_item.value !== exp_r.value) begin
						$display("%0t: value mismatch expected %0d actual %0d",
							$time, exp_r.value, out_item.value);
						errors++;
					end
					if (out_item.error !== exp_r.error) begin
						$display("%0t: error flag mismatch expected %0b actual %0b",
							$time, exp_r.error, out_item.error);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("barometric_pressure_compensation_tb: errors");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < bpc_pkg::REG_OSS) cal_regs[idx] = data;
		else if (idx == bpc_pkg::REG_OSS) oss_reg = data[1:0];
	endtask

	// wait until nothing is queued, offered or in flight; sampled between edges
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic bpc_pkg::in_item_t make_item(input logic op, input logic [23:0] raw);
		bpc_pkg::in_item_t it;
		it.operation = op;
		it.raw_value = raw;
		return it;
	endfunction

	// typical datasheet-like calibration
	task automatic load_typical();
		write_reg(bpc_pkg::REG_AC1_AC2, {16'd408, 16'hFFC4});
		write_reg(bpc_pkg::REG_AC3_AC4, {16'hC696, 16'd32741});
		write_reg(bpc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
		write_reg(bpc_pkg::REG_B1_B2,   {16'd6190, 16'd4});
		write_reg(bpc_pkg::REG_MC_MD,   {16'h8000, 16'd2868});
	endtask

	// calibration from fixed random ranges per coefficient, sometimes fully random
	task automatic load_random_cal();
		if ($urandom_range(4) == 0) begin
			for (int i = 0; i < 5; i++) write_reg(i[2:0], $urandom);
		end else begin
			write_reg(bpc_pkg::REG_AC1_AC2,
				{16'(7000 + $urandom_range(2000)), 16'(-1400 + $urandom_range(800))});
			write_reg(bpc_pkg::REG_AC3_AC4,
				{16'(-15000 + $urandom_range(2000)), 16'(30000 + $urandom_range(5000))});
			write_reg(bpc_pkg::REG_AC5_AC6,
				{16'(24000 + $urandom_range(10000)), 16'(18000 + $urandom_range(6000))});
			write_reg(bpc_pkg::REG_B1_B2,
				{16'(5000 + $urandom_range(2000)), 16'($urandom_range(100))});
			write_reg(bpc_pkg::REG_MC_MD,
				{16'(-12000 + $urandom_range(4000)), 16'(2000 + $urandom_range(1500))});
		end
		write_reg(bpc_pkg::REG_OSS, $urandom_range(3));
	endtask

	int phase_items;
	initial begin
		arst_n = 1'b1;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 5; i++) cal_regs[i] = '0;
		oss_reg = '0;
		b5_term = '0;
		#1;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pressure before any temperature with all-zero calibration: zero divisors
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h000000));
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'h000000));
		drain();

		// directed: extremes with typical calibration
		load_typical();
		write_reg(bpc_pkg::REG_OSS, 2'd0);
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h5D2300));
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'h006C_FA));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h5D2300));
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'hFF0000));
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'h00FFFF));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'hFFFFFF));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h000000));
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'h000000));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'hAAAAAA));
		drain();
		write_reg(bpc_pkg::REG_OSS, 2'd3);
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'h5555));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h555555));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'hFFFFFF));
		drain();
		// temperature divisor forced to zero: MD cancels X1 (X1 = 0 when UT = AC6)
		write_reg(bpc_pkg::REG_MC_MD, {16'h7FFF, 16'h0000});
		write_reg(bpc_pkg::REG_AC5_AC6, {16'hFFFF, 16'h1234});
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'h001234));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h800000));
		drain();
		// pressure divisor zero: AC4 = 0
		write_reg(bpc_pkg::REG_AC3_AC4, {16'h8000, 16'h0000});
		write_reg(bpc_pkg::REG_B1_B2, {16'h7FFF, 16'h8000});
		write_reg(bpc_pkg::REG_AC1_AC2, {16'h8000, 16'h7FFF});
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h123456));
		drain();
		write_reg(bpc_pkg::REG_AC3_AC4, {16'h7FFF, 16'hFFFF});
		write_reg(bpc_pkg::REG_OSS, 2'd1);
		pending_items.push_back(make_item(bpc_pkg::OP_TEMP, 24'hFFFFFF));
		pending_items.push_back(make_item(bpc_pkg::OP_PRESS, 24'h7FFFFF));
		drain();

		// random phases: mostly pressure items with temperature items mixed in
		for (int ph = 0; ph < 12; ph++) begin
			load_random_cal();
			phase_items = RAND_ITEMS / 12;
			for (int n = 0; n < phase_items; n++) begin
				if ($urandom_range(3) == 0)
					pending_items.push_back(make_item(bpc_pkg::OP_TEMP,
						{8'($urandom), 16'(24000 + $urandom_range(12000))}));
				else if ($urandom_range(15) == 0)
					pending_items.push_back(make_item(1'($urandom_range(1)),
						24'($urandom)));
				else
					pending_items.push_back(make_item(bpc_pkg::OP_PRESS,
						24'(23'h500000 + $urandom_range(24'h400000))));
				// sender holds until all results are back
				if (n == phase_items / 2 && ph == 3) begin
					@(negedge clk);
					while (pending_items.size() > 0 || in_valid) @(negedge clk);
					hold_sender = 1;
					while (expected_results.size() > 0) @(negedge clk);
					hold_sender = 0;
				end
			end
			drain();
		end

		$display("Checked %0d result transactions (%0d with zero divisor) over",
			results_seen, div_errors_seen);
		$display("12 random calibrations plus directed extremes at several oversampling settings.");
		if (errors == 0) begin
			$display("barometric_pressure_compensation_tb: clean");
		end else begin
			$display("barometric_pressure_compensation_tb: errors");
		end
		$finish;
	end

endmodule
